// File: src/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

	typedef logic [3:0] bcd_t;
	typedef logic [5:0] ascii_t;

	// Control that the sequencer broadcasts to every digit cell
	typedef struct packed {
		logic clear;   // zero the digit at the start of a transaction
		logic conv;    // one double-dabble step: adjust, then shift in a bit
		logic emit;    // shift digits one place toward the top cell
	} cell_ctrl_t;

	localparam bcd_t   DIGIT_ADJ_MIN = 4'd5;
	localparam bcd_t   DIGIT_ADJ     = 4'd3;
	localparam ascii_t ASCII_ZERO    = 6'd48;

endpackage

// File: src/b2da_cell.sv
// ----------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the double-dabble chain; also shifts digits out.
// ----------------------------------------------------------------------------
module b2da_cell (
	input  logic                   clk,
	input  b2da_pkg::cell_ctrl_t   ctrl,
	input  logic                   carry_in,
	input  b2da_pkg::bcd_t         digit_in,
	output logic                   carry_out,
	output b2da_pkg::bcd_t         digit
);
	import b2da_pkg::*;

	bcd_t digit_q;
	bcd_t adj;

	// Add three when the digit is five or more, so the shift carries correctly
	always_comb begin
		adj = (digit_q >= DIGIT_ADJ_MIN) ? bcd_t'(digit_q + DIGIT_ADJ) : digit_q;
	end

	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.conv) begin
			digit_q <= {adj[2:0], carry_in};
		end else if (ctrl.emit) begin
			digit_q <= digit_in;
		end
	end

endmodule

// File: src/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Serial double-dabble converter from binary to ASCII decimal digits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (value_valid / value_ready / value) takes one unsigned
//   integer per transaction. Output channel (digit_valid / digit_ready /
//   digit_char / last) returns its decimal digits as ASCII, most
//   significant first, with last set on the final digit. Zero gives '0'.
//
// Sequence:
//   After acceptance the value shifts through a chain of NUM_DIGITS BCD
//   cells, one bit per cycle. The chain then shifts toward the top cell
//   one digit per cycle while the output slot is free or a leading zero
//   is skipped, dropping leading zeros and presenting the others.
//
// Reset and stalls:
//   arst_n clears the sequencer and the output valid flag. When the
//   receiver stalls, the output register holds its digit and the chain
//   holds until the slot frees; leading-zero skips continue meanwhile.
//   A new value is accepted once the previous item has handed over its
//   last digit to the output register, even while that digit waits.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 63
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   value_valid,
	output logic                   value_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   digit_valid,
	input  logic                   digit_ready,
	output b2da_pkg::ascii_t       digit_char,
	output logic                   last
);
	import b2da_pkg::*;

	// floor(W * log10(2)) + 1 digits cover every W-bit value
	localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int CNT_W      = $clog2(VALUE_WIDTH);
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   started_q;
	logic [VALUE_WIDTH-1:0] val_q;

	logic                   out_valid_q;
	ascii_t                 digit_char_q;
	logic                   last_q;

	logic                   accept;
	logic                   slot_free;
	logic                   skip;
	logic                   emit_go;
	bcd_t                   top_digit;
	cell_ctrl_t             ctrl;

	logic                   carry [NUM_DIGITS];
	bcd_t                   dig   [NUM_DIGITS];

	assign value_ready = (state_q == ST_IDLE);
	assign accept      = value_valid && value_ready;
	assign slot_free   = !out_valid_q || digit_ready;
	assign top_digit   = dig[NUM_DIGITS-1];

	// Drop leading zeros without touching the output slot; never drop the last digit
	assign skip    = (state_q == ST_EMIT) && !started_q && (top_digit == '0)
			&& (rem_q != REM_W'(1));
	assign emit_go = (state_q == ST_EMIT) && !skip && slot_free;

	assign ctrl.clear = accept;
	assign ctrl.conv  = (state_q == ST_CONV);
	assign ctrl.emit  = skip || emit_go;

	// Cell chain: bits enter at cell 0, digits leave from the top cell
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			b2da_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.carry_in  (val_q[VALUE_WIDTH-1]),
				.digit_in  ('0),
				.carry_out (carry[i]),
				.digit     (dig[i])
			);
		end else begin : g_rest
			b2da_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.carry_in  (carry[i-1]),
				.digit_in  (dig[i-1]),
				.carry_out (carry[i]),
				.digit     (dig[i])
			);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rem_q     <= '0;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
						cnt_q   <= CNT_W'(VALUE_WIDTH - 1);
					end
				end
				ST_CONV: begin
					if (cnt_q == '0) begin
						state_q   <= ST_EMIT;
						rem_q     <= REM_W'(NUM_DIGITS);
						started_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (skip) begin
						rem_q <= rem_q - 1'b1;
					end else if (emit_go) begin
						rem_q     <= rem_q - 1'b1;
						started_q <= 1'b1;
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Value shift register: load on accept, advance MSB first while converting
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
		end else if (state_q == ST_CONV) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (digit_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			digit_char_q <= ASCII_ZERO + ascii_t'(top_digit);
			last_q       <= (rem_q == REM_W'(1));
		end
	end

	assign digit_valid = out_valid_q;
	assign digit_char  = digit_char_q;
	assign last        = last_q;

	// Assertions
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV) && (cnt_q == CNT_W'(VALUE_WIDTH - 1)))
		else $error("conversion did not start after acceptance");

	a_emit_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_q != '0))
		else $error("emit phase with no digits remaining");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9))
		else $error("output character is not a decimal digit");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && !started_q) |-> (top_digit != '0) || (rem_q == REM_W'(1)))
		else $error("leading zero presented");

endmodule
